// File: design/binary_heap_priority_queue_macros.svh
// Assertion helpers for the heap queue checker
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define BHPQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BHPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bhpq_pkg.sv
package bhpq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int POS_W     = $clog2(CAPACITY + 1);
    localparam int ADDR_W    = $clog2(CAPACITY);

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [POS_W-1:0]            pos_t;
    typedef logic [ADDR_W-1:0]           addr_t;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        action_t action;
        key_t    value;
    } in_item_t;

    typedef struct packed {
        status_t status;
        key_t    popped_value;
        key_t    top_value;
        logic    top_valid;
        pos_t    count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PU_CHK,
        ST_PU_CMP,
        ST_POP_ROOT,
        ST_POP_LAST,
        ST_POP_LAT,
        ST_SD_CHK,
        ST_SD_L,
        ST_SD_R,
        ST_SD_CMP,
        ST_WR_ELEM,
        ST_TOP_RD,
        ST_TOP_LAT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    lat_popped;
        logic    lat_last;
        logic    pu_step;
        logic    wr_elem;
        logic    lat_left;
        logic    lat_right;
        logic    sd_step;
        logic    lat_top;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic hole_root;
        logic child_in;
        logic right_in;
        logic elem_first;
        logic cand_first;
    } dp_stat_t;

    function automatic logic comes_first(logic mode, key_t a, key_t b);
        return mode ? (a > b) : (a < b);
    endfunction

endpackage

// File: design/bhpq_ctrl.sv
module bhpq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  bhpq_pkg::action_t s_action,
    output logic              s_ready,
    input  logic              m_ready,
    output logic              m_valid,
    input  bhpq_pkg::dp_stat_t stat,
    output bhpq_pkg::dp_cmd_t  cmd
);
    import bhpq_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_PUSH) begin
                        state_next = stat.full ? ST_TOP_RD : ST_PU_CHK;
                    end else begin
                        state_next = stat.empty ? ST_TOP_RD : ST_POP_ROOT;
                    end
                end
            end
            ST_PU_CHK:   state_next = stat.hole_root ? ST_WR_ELEM : ST_PU_CMP;
            ST_PU_CMP:   state_next = stat.elem_first ? ST_PU_CHK : ST_WR_ELEM;
            ST_POP_ROOT: state_next = ST_POP_LAST;
            ST_POP_LAST: state_next = ST_POP_LAT;
            ST_POP_LAT:  state_next = ST_SD_CHK;
            ST_SD_CHK:   state_next = stat.child_in ? ST_SD_L : ST_WR_ELEM;
            ST_SD_L:     state_next = stat.right_in ? ST_SD_R : ST_SD_CMP;
            ST_SD_R:     state_next = ST_SD_CMP;
            ST_SD_CMP:   state_next = stat.cand_first ? ST_SD_CHK : ST_WR_ELEM;
            ST_WR_ELEM:  state_next = ST_TOP_RD;
            ST_TOP_RD:   state_next = ST_TOP_LAT;
            ST_TOP_LAT:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.rd_sel   = RD_ROOT;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE:     cmd.accept = s_valid;
            ST_PU_CHK: begin
                cmd.rd_en  = !stat.hole_root;
                cmd.rd_sel = RD_PARENT;
            end
            ST_PU_CMP:   cmd.pu_step = stat.elem_first;
            ST_POP_ROOT: cmd.rd_en = 1'b1;
            ST_POP_LAST: begin
                cmd.lat_popped = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = RD_LAST;
            end
            ST_POP_LAT:  cmd.lat_last = 1'b1;
            ST_SD_CHK: begin
                cmd.rd_en  = stat.child_in;
                cmd.rd_sel = RD_LEFT;
            end
            ST_SD_L: begin
                cmd.lat_left = 1'b1;
                cmd.rd_en    = stat.right_in;
                cmd.rd_sel   = RD_RIGHT;
            end
            ST_SD_R:     cmd.lat_right = 1'b1;
            ST_SD_CMP:   cmd.sd_step = stat.cand_first;
            ST_WR_ELEM:  cmd.wr_elem = 1'b1;
            ST_TOP_RD:   cmd.rd_en = 1'b1;
            ST_TOP_LAT:  cmd.lat_top = 1'b1;
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: design/bhpq_datapath.sv
module bhpq_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  bhpq_pkg::in_item_t  s_item,
    output bhpq_pkg::out_item_t m_item,
    input  bhpq_pkg::dp_cmd_t   cmd,
    output bhpq_pkg::dp_stat_t  stat
);
    import bhpq_pkg::*;

    key_t heap_mem [CAPACITY];

    logic      mode_reg, mode_next;
    pos_t      count_reg, count_next;
    pos_t      hole_reg, hole_next;
    pos_t      cand_pos_reg, cand_pos_next;
    key_t      elem_reg, elem_next;
    key_t      cand_reg, cand_next;
    key_t      popped_reg, popped_next;
    key_t      top_reg, top_next;
    status_t   status_reg, status_next;
    out_item_t out_reg, out_next;
    key_t      rd_data_reg;

    logic [POS_W:0] child;
    pos_t           child_pos;
    pos_t           rd_pos;
    addr_t          rd_addr;
    addr_t          wr_addr;
    logic           wr_en;
    key_t           wr_data;

    assign child     = {hole_reg, 1'b0};
    assign child_pos = child[POS_W-1:0];

    assign stat.full       = (count_reg == pos_t'(CAPACITY));
    assign stat.empty      = (count_reg == '0);
    assign stat.hole_root  = (hole_reg == pos_t'(1));
    assign stat.child_in   = (child <= {1'b0, count_reg});
    assign stat.right_in   = (child < {1'b0, count_reg});
    assign stat.elem_first = comes_first(mode_reg, elem_reg, rd_data_reg);
    assign stat.cand_first = comes_first(mode_reg, cand_reg, elem_reg);

    always_comb begin
        case (cmd.rd_sel)
            RD_ROOT:   rd_pos = pos_t'(1);
            RD_LAST:   rd_pos = count_reg;
            RD_PARENT: rd_pos = hole_reg >> 1;
            RD_LEFT:   rd_pos = child_pos;
            RD_RIGHT:  rd_pos = child_pos + pos_t'(1);
            default:   rd_pos = pos_t'(1);
        endcase
    end

    assign rd_addr = addr_t'(rd_pos - pos_t'(1));
    assign wr_addr = addr_t'(hole_reg - pos_t'(1));
    assign wr_en   = cmd.pu_step || cmd.wr_elem || cmd.sd_step;
    assign wr_data = cmd.pu_step ? rd_data_reg : (cmd.sd_step ? cand_reg : elem_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    always_comb begin
        mode_next     = cfg_wr_en ? cfg_wr_data : mode_reg;
        count_next    = count_reg;
        hole_next     = hole_reg;
        cand_pos_next = cand_pos_reg;
        elem_next     = elem_reg;
        cand_next     = cand_reg;
        popped_next   = popped_reg;
        top_next      = top_reg;
        status_next   = status_reg;
        out_next      = out_reg;

        if (cmd.accept) begin
            popped_next = '0;
            status_next = STATUS_OK;
            if (s_item.action == ACT_PUSH) begin
                if (stat.full) begin
                    status_next = STATUS_FULL;
                end else begin
                    elem_next  = s_item.value;
                    hole_next  = count_reg + pos_t'(1);
                    count_next = count_reg + pos_t'(1);
                end
            end else if (stat.empty) begin
                status_next = STATUS_EMPTY;
            end
        end
        if (cmd.lat_popped) begin
            popped_next = rd_data_reg;
        end
        if (cmd.lat_last) begin
            elem_next  = rd_data_reg;
            count_next = count_reg - pos_t'(1);
            hole_next  = pos_t'(1);
        end
        if (cmd.pu_step) begin
            hole_next = hole_reg >> 1;
        end
        if (cmd.lat_left) begin
            cand_next     = rd_data_reg;
            cand_pos_next = child_pos;
        end
        if (cmd.lat_right && comes_first(mode_reg, rd_data_reg, cand_reg)) begin
            cand_next     = rd_data_reg;
            cand_pos_next = child_pos + pos_t'(1);
        end
        if (cmd.sd_step) begin
            hole_next = cand_pos_reg;
        end
        if (cmd.lat_top) begin
            top_next = rd_data_reg;
        end
        if (cmd.out_load) begin
            out_next.status       = status_reg;
            out_next.popped_value = popped_reg;
            out_next.top_value    = stat.empty ? key_t'(0) : top_reg;
            out_next.top_valid    = !stat.empty;
            out_next.count        = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
        hole_reg     <= hole_next;
        cand_pos_reg <= cand_pos_next;
        elem_reg     <= elem_next;
        cand_reg     <= cand_next;
        popped_reg   <= popped_next;
        top_reg      <= top_next;
        status_reg   <= status_next;
        out_reg      <= out_next;
    end

    assign m_item = out_reg;

endmodule

// File: design/binary_heap_priority_queue.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_item  (action, value)
// m_        out        m_valid / m_ready  m_item  (status, popped_value, top_value,
//                                                 top_valid, count)
// cfg_      in         cfg_wr_en          cfg_wr_data (order_mode)
//
// One item at a time; the heap sits in a single-port-read RAM with registered read data.
// Push sifts a new key up, pop sifts the last key down from the root, 10 levels at most;
// refused items only read the top. Each level costs one RAM read per key compared.
// aresetn (sync, active low) empties the queue and selects smallest-first; no clearing pass.
// A held result in the m_ register does not block the next s_ item, only its completion.
module binary_heap_priority_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bhpq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bhpq_pkg::out_item_t m_item,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data
);
    import bhpq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_item.action),
        .s_ready  (s_ready),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    bhpq_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .m_item      (m_item),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// File: design/bhpq_checker.sv
`include "binary_heap_priority_queue_macros.svh"

module bhpq_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bhpq_pkg::out_item_t m_item
);
    import bhpq_pkg::*;

    `BHPQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result item dropped or changed while stalled")
    `BHPQ_ASSERT_NOW(a_top_valid, aclk, aresetn, m_valid, m_item.top_valid == (m_item.count != '0), "top_valid disagrees with count")
    `BHPQ_ASSERT_NOW(a_top_zero, aclk, aresetn, m_valid && !m_item.top_valid, m_item.top_value == '0, "top_value not zero on empty queue")
    `BHPQ_ASSERT_NOW(a_refused_pop, aclk, aresetn, m_valid && m_item.status != STATUS_OK, m_item.popped_value == '0, "refused item reports a popped key")

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (.*);

// File: verif/bhpq_result_checker.sv
`timescale 1ns / 100ps

module bhpq_result_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  bhpq_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  bhpq_pkg::out_item_t m_item,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    output int                  fail_count,
    output int                  results_pending
);
    import bhpq_pkg::*;

    key_t      heap_keys [1:CAPACITY];
    int        held         = 0;
    logic      order_desc   = 1'b0;
    out_item_t pending_results [$];
    int        mismatches   = 0;
    int        awaiting     = 0;
    int        results_seen = 0;

    assign fail_count      = mismatches;
    assign results_pending = awaiting;

    function automatic logic served_before(key_t a, key_t b);
        return order_desc ? (a > b) : (a < b);
    endfunction

    // updates the shadow heap and returns the result the item should produce
    function automatic out_item_t apply_heap_op(in_item_t it);
        out_item_t r;
        key_t      moving;
        int        hole;
        int        kid;
        r = '0;
        r.status = STATUS_OK;
        if (it.action == ACT_PUSH) begin
            if (held >= CAPACITY) begin
                r.status = STATUS_FULL;
            end else begin
                held++;
                hole   = held;
                moving = it.value;
                while (hole > 1 && served_before(moving, heap_keys[hole / 2])) begin
                    heap_keys[hole] = heap_keys[hole / 2];
                    hole = hole / 2;
                end
                heap_keys[hole] = moving;
            end
        end else begin
            if (held == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.popped_value = heap_keys[1];
                moving = heap_keys[held];
                held--;
                if (held > 0) begin
                    hole = 1;
                    kid  = 2;
                    while (kid <= held) begin
                        if (kid < held && served_before(heap_keys[kid + 1], heap_keys[kid]))
                            kid++;
                        if (!served_before(heap_keys[kid], moving))
                            break;
                        heap_keys[hole] = heap_keys[kid];
                        hole = kid;
                        kid  = 2 * hole;
                    end
                    heap_keys[hole] = moving;
                end
            end
        end
        r.top_valid = (held > 0);
        r.top_value = (held > 0) ? heap_keys[1] : key_t'(0);
        r.count     = pos_t'(held);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item, count %0d", got.count));
        end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("item %0d status %0d, expected %0d",
                                          results_seen, got.status, want.status));
            if (got.popped_value !== want.popped_value)
                report_mismatch($sformatf("item %0d popped_value %0d, expected %0d",
                                          results_seen, got.popped_value, want.popped_value));
            if (got.top_value !== want.top_value)
                report_mismatch($sformatf("item %0d top_value %0d, expected %0d",
                                          results_seen, got.top_value, want.top_value));
            if (got.top_valid !== want.top_valid)
                report_mismatch($sformatf("item %0d top_valid %0d, expected %0d",
                                          results_seen, got.top_valid, want.top_valid));
            if (got.count !== want.count)
                report_mismatch($sformatf("item %0d count %0d, expected %0d",
                                          results_seen, got.count, want.count));
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held       = 0;
            order_desc = 1'b0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready)
                check_result(m_item);
            if (s_valid && s_ready)
                pending_results.insert(pending_results.size(), apply_heap_op(s_item));
            if (cfg_wr_en)
                order_desc = cfg_wr_data;
        end
        awaiting <= pending_results.size();
    end

endmodule

// File: verif/binary_heap_priority_queue_tb.sv
`timescale 1ns / 100ps

module binary_heap_priority_queue_tb;
    import bhpq_pkg::*;

    logic      aclk        = 1'b0;
    logic      aresetn     = 1'b0;
    logic      s_valid     = 1'b0;
    logic      s_ready;
    in_item_t  s_item      = '0;
    logic      m_valid;
    logic      m_ready     = 1'b0;
    out_item_t m_item;
    logic      cfg_wr_en   = 1'b0;
    logic      cfg_wr_data = 1'b0;

    int   fail_count;
    int   results_pending;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_req      = 1'b0;
    logic hold_taken    = 1'b0;
    int   hold_left     = 0;
    int   queue_fill    = 0;

    binary_heap_priority_queue i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    bhpq_result_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always #1 aclk = ~aclk;

    // receiver: random stalls, plus one long hold-off so the queue backs up
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            m_ready    <= 1'b0;
            hold_left  <= 300;
            hold_taken <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("binary_heap_priority_queue test failed");
        $finish;
    end

    function automatic key_t pick_key();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return {1'b1, {(KEY_WIDTH-1){1'b0}}};
            1: return {1'b0, {(KEY_WIDTH-1){1'b1}}};
            2, 3: return key_t'($signed($urandom_range(8)) - 4);
            default: return key_t'($urandom);
        endcase
    endfunction

    task automatic offer(input action_t act, input key_t key);
        in_item_t nxt;
        nxt.action = act;
        nxt.value  = key;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= nxt;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (act == ACT_PUSH && queue_fill < CAPACITY)
            queue_fill++;
        else if (act == ACT_POP && queue_fill > 0)
            queue_fill--;
    endtask

    task automatic run_mixed(input int n, input int push_pct);
        repeat (n) begin
            if ($urandom_range(99) < push_pct)
                offer(ACT_PUSH, pick_key());
            else
                offer(ACT_POP, pick_key());
        end
    endtask

    // only once every item has come back and the block has settled
    task automatic set_order(input logic desc);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= desc;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest first: pop on empty, extremes, ties, drain past empty
        offer(ACT_POP, 32'h5A5A_A5A5);
        offer(ACT_PUSH, 32'h8000_0000);
        offer(ACT_PUSH, 32'h7FFF_FFFF);
        offer(ACT_PUSH, 32'h0000_0000);
        offer(ACT_PUSH, 32'hFFFF_FFFF);
        offer(ACT_PUSH, 32'h0000_0001);
        offer(ACT_PUSH, 32'd7);
        offer(ACT_PUSH, 32'd7);
        offer(ACT_PUSH, -32'sd7);
        offer(ACT_PUSH, 32'h7FFF_FFFF);
        repeat (10) offer(ACT_POP, 32'hFFFF_FFFF);

        // largest first
        set_order(1'b1);
        offer(ACT_PUSH, 32'd3);
        offer(ACT_PUSH, 32'h8000_0000);
        offer(ACT_PUSH, 32'h7FFF_FFFF);
        offer(ACT_PUSH, 32'd3);
        offer(ACT_POP, 32'h0000_0000);
        offer(ACT_POP, 32'h0000_0000);

        run_mixed(60, 60);

        // mode flips with keys held
        set_order(1'b0);
        send_idle_pct = 70;
        run_mixed(60, 60);

        // fill to capacity under receiver back-pressure
        send_idle_pct = 0;
        stall_pct     = 70;
        hold_req     <= 1'b1;
        while (queue_fill < CAPACITY)
            offer(ACT_PUSH, pick_key());
        repeat (8) offer(ACT_PUSH, pick_key());
        run_mixed(30, 55);

        set_order(1'b1);
        send_idle_pct = 19;
        stall_pct     = 19;
        run_mixed(60, 30);

        set_order(1'b0);
        send_idle_pct = 0;
        stall_pct     = 0;
        run_mixed(30, 50);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        if (fail_count == 0)
            $display("binary_heap_priority_queue test passed");
        else
            $display("binary_heap_priority_queue test failed");
        $finish;
    end

endmodule
